// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i and gated by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define CLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that expr is never true outside reset.
`define CLE_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== src/cle_pkg.sv =====
package cle_pkg;

  localparam int unsigned DepthDefault = 128;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharBs    = 8'h08;
  localparam logic [7:0] CharDel   = 8'h7F;
  localparam logic [7:0] CharCtrlW = 8'h17;
  localparam logic [7:0] CharCtrlU = 8'h15;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [2:0] {
    EK_NONE  = 3'd0,
    EK_ECHO  = 3'd1,
    EK_BELL  = 3'd2,
    EK_CRLF  = 3'd3,
    EK_ERASE = 3'd4
  } echo_kind_e;

  typedef enum logic {
    STEP_INC = 1'b0,
    STEP_DEC = 1'b1
  } step_dir_e;

  // Tab, newline, vertical tab, form feed, carriage return and space.
  function automatic logic is_white(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

endpackage

// ===== src/console_line_editor_unit.sv =====
// Console line editor.
// Input words: tuser selects the action (0 receive tdata as a typed byte,
// 1 pop one byte of the closed line). Every input word yields exactly one
// output word: tuser carries echo kind, refused and read-valid flags, tdata
// the echo byte, erase count and popped byte.
// An input word is taken only while the sequencer is idle. Plain edits, CR,
// refused receives and pops with no closed line go from the execute state
// straight to finish; a pop of a character passes a read state (one read of
// the line memory), and Ctrl-W on a non-empty line passes the scan state,
// which the single read port of the line memory makes walk backward one
// byte a cycle. tready rises on the edge that loads the output word, so a
// new word is taken only after the result of the last one is loaded.
// The output word sits in a register; a stalled receiver holds it there,
// and the next finished result waits in the sequencer until it drains,
// while intake stays closed.
// Reset empties the line and opens it for editing; the line memory itself
// is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module console_line_editor_unit
  import cle_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_char
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] echo_char, [15:8] erase_count,
                                        // [23:16] read_char
  output logic [4:0]  m_axis_tuser_o    // [2:0] echo_kind, [3] refused,
                                        // [4] read_valid
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = (IW > 8) ? IW : 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WSCAN,
    ST_RDATA,
    ST_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] wr_q, wr_d;
  logic [IW-1:0] rd_q, rd_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic          closed_q, closed_d;
  logic          action_q, action_d;
  logic [7:0]    char_q, char_d;

  echo_kind_e    res_kind_q, res_kind_d;
  logic [7:0]    res_echo_q, res_echo_d;
  logic [7:0]    res_count_q, res_count_d;
  logic          res_refused_q, res_refused_d;
  logic          res_rvalid_q, res_rvalid_d;
  logic [7:0]    res_rchar_q, res_rchar_d;

  logic          out_valid_q, out_valid_d;
  logic [23:0]   out_data_q, out_data_d;
  logic [4:0]    out_user_q, out_user_d;

  logic          out_free;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  logic [IW-1:0] step_a;
  step_dir_e     step_dir;
  logic [IW-1:0] step_res;
  logic [IW-1:0] line_len;
  logic          len_zero;
  logic          line_full;
  logic [CW-1:0] len_ext;
  logic [7:0]    len_sat;

  cle_idx_unit #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_idx (
    .step_a_i   (step_a),
    .step_dir_i (step_dir),
    .step_o     (step_res),
    .wr_idx_i   (wr_q),
    .rd_idx_i   (rd_q),
    .len_o      (line_len),
    .len_zero_o (len_zero),
    .full_o     (line_full)
  );

  // Read address is the next pointer, so the data register tracks ptr_q.
  cle_line_ram #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_q),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_d),
    .rdata_o (mem_rdata)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign len_ext  = CW'(line_len);
  assign len_sat  = (len_ext > CW'(255)) ? 8'hFF : len_ext[7:0];

  // Operand and direction of the shared index stepper.
  always_comb begin
    step_a   = wr_q;
    step_dir = STEP_INC;
    unique case (state_q)
      ST_EXEC: begin
        step_a   = wr_q;
        step_dir = ((char_q == CharBs) || (char_q == CharDel) ||
                    (char_q == CharCtrlW)) ? STEP_DEC : STEP_INC;
      end
      ST_WSCAN: begin
        step_a   = ptr_q;
        step_dir = STEP_DEC;
      end
      ST_RDATA: begin
        step_a   = rd_q;
        step_dir = STEP_INC;
      end
      default: begin
        step_a   = wr_q;
        step_dir = STEP_INC;
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    wr_d          = wr_q;
    rd_d          = rd_q;
    ptr_d         = ptr_q;
    closed_d      = closed_q;
    action_d      = action_q;
    char_d        = char_q;
    res_kind_d    = res_kind_q;
    res_echo_d    = res_echo_q;
    res_count_d   = res_count_q;
    res_refused_d = res_refused_q;
    res_rvalid_d  = res_rvalid_q;
    res_rchar_d   = res_rchar_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_data_d    = out_data_q;
    out_user_d    = out_user_q;
    mem_we        = 1'b0;
    mem_wdata     = char_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          action_d = s_axis_tuser_i;
          char_d   = s_axis_tdata_i;
          state_d  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_kind_d    = EK_NONE;
        res_echo_d    = '0;
        res_count_d   = '0;
        res_refused_d = 1'b0;
        res_rvalid_d  = 1'b0;
        res_rchar_d   = '0;
        state_d       = ST_FINISH;
        if (action_q) begin
          if (closed_q && !len_zero) begin
            ptr_d   = rd_q;
            state_d = ST_RDATA;
          end
        end else if (closed_q) begin
          res_refused_d = 1'b1;
        end else begin
          unique case (char_q) inside
            CharCr: begin
              mem_we     = 1'b1;
              mem_wdata  = CharNl;
              wr_d       = step_res;
              closed_d   = 1'b1;
              res_kind_d = EK_CRLF;
            end
            CharBs, CharDel: begin
              if (len_zero) begin
                res_kind_d = EK_BELL;
              end else begin
                wr_d        = step_res;
                res_kind_d  = EK_ERASE;
                res_count_d = 8'd1;
              end
            end
            CharCtrlW: begin
              res_kind_d = EK_ERASE;
              if (!len_zero) begin
                ptr_d   = step_res;
                state_d = ST_WSCAN;
              end
            end
            CharCtrlU: begin
              res_kind_d  = EK_ERASE;
              res_count_d = len_sat;
              wr_d        = rd_q;
            end
            default: begin
              if (line_full) begin
                res_kind_d = EK_BELL;
              end else begin
                mem_we     = 1'b1;
                wr_d       = step_res;
                res_kind_d = EK_ECHO;
                res_echo_d = char_q;
              end
            end
          endcase
        end
      end

      // mem_rdata holds the byte just before the tail.
      ST_WSCAN: begin
        if (len_zero || is_white(mem_rdata)) begin
          state_d = ST_FINISH;
        end else begin
          wr_d  = ptr_q;
          ptr_d = step_res;
          if (res_count_q != 8'hFF) begin
            res_count_d = res_count_q + 8'd1;
          end
        end
      end

      ST_RDATA: begin
        res_rvalid_d = 1'b1;
        res_rchar_d  = mem_rdata;
        rd_d         = step_res;
        if (step_res == wr_q) begin
          closed_d = 1'b0;
        end
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {res_rchar_q, res_count_q, res_echo_q};
          out_user_d  = {res_rvalid_q, res_refused_q, res_kind_q};
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wr_q          <= '0;
      rd_q          <= '0;
      ptr_q         <= '0;
      closed_q      <= 1'b0;
      action_q      <= 1'b0;
      char_q        <= '0;
      res_kind_q    <= EK_NONE;
      res_echo_q    <= '0;
      res_count_q   <= '0;
      res_refused_q <= 1'b0;
      res_rvalid_q  <= 1'b0;
      res_rchar_q   <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      out_user_q    <= '0;
    end else begin
      state_q       <= state_d;
      wr_q          <= wr_d;
      rd_q          <= rd_d;
      ptr_q         <= ptr_d;
      closed_q      <= closed_d;
      action_q      <= action_d;
      char_q        <= char_d;
      res_kind_q    <= res_kind_d;
      res_echo_q    <= res_echo_d;
      res_count_q   <= res_count_d;
      res_refused_q <= res_refused_d;
      res_rvalid_q  <= res_rvalid_d;
      res_rchar_q   <= res_rchar_d;
      out_valid_q   <= out_valid_d;
      out_data_q    <= out_data_d;
      out_user_q    <= out_user_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `CLE_ASSERT(a_intake_closes, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o,
              "intake still open after an accepted word")
  `CLE_ASSERT_NEVER(a_closed_nonempty, closed_q && len_zero,
                    "closed line with no characters")
  `CLE_ASSERT(a_finish_loads, (state_q == ST_FINISH && out_free) |=> m_axis_tvalid_o,
              "finished result not presented")

endmodule

// ===== src/cle_line_ram.sv =====
module cle_line_ram
  import cle_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [IW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cle_idx_unit.sv =====
module cle_idx_unit
  import cle_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic [IW-1:0] step_a_i,
  input  step_dir_e     step_dir_i,
  output logic [IW-1:0] step_o,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [IW-1:0] rd_idx_i,
  output logic [IW-1:0] len_o,
  output logic          len_zero_o,
  output logic          full_o
);

  localparam logic [IW-1:0] LastIdx  = IW'(DEPTH - 1);
  localparam logic [IW-1:0] FullLen  = IW'(DEPTH - 2);
  localparam logic [IW:0]   DepthExt = (IW + 1)'(DEPTH);

  logic [IW:0] diff;

  // Circular step around the store.
  always_comb begin
    step_o = '0;
    case (step_dir_i)
      STEP_INC: step_o = (step_a_i == LastIdx) ? '0 : step_a_i + IW'(1);
      STEP_DEC: step_o = (step_a_i == '0) ? LastIdx : step_a_i - IW'(1);
      default:  step_o = step_a_i;
    endcase
  end

  always_comb begin
    diff = {1'b0, wr_idx_i} - {1'b0, rd_idx_i};
    if (wr_idx_i < rd_idx_i) begin
      diff = diff + DepthExt;
    end
  end

  assign len_o      = diff[IW-1:0];
  assign len_zero_o = (len_o == '0);
  // Keep one slot for the newline.
  assign full_o     = (len_o >= FullLen);

endmodule

// ===== tb/sv/tb_console_line_editor_unit.sv =====
module tb_console_line_editor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int unsigned DEPTH       = DepthDefault;
  localparam int unsigned WORD_COUNT  = 1200;
  localparam int unsigned CALM_AFTER  = 1020;
  localparam longint      CYCLE_LIMIT = 1_000_000;

  typedef enum bit {
    ACT_RX  = 1'b0,
    ACT_POP = 1'b1
  } act_e;

  typedef struct packed {
    echo_kind_e kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       refused;
    logic       read_valid;
    logic [7:0] read_char;
  } reply_t;

  // Tracks the line the block should hold and the replies it owes.
  class echo_tracker;
    logic [7:0] line_buf [DEPTH];
    int         tail;
    int         head;
    bit         closed;
    reply_t     pending_replies [$];
    int         errors;

    function new();
      tail   = 0;
      head   = 0;
      closed = 1'b0;
      errors = 0;
    endfunction

    function int fill();
      return (tail + DEPTH - head) % DEPTH;
    endfunction

    function bit blank(logic [7:0] c);
      return c inside {[CharTab:CharCr], CharSpace};
    endfunction

    function reply_t edit_line(act_e act, logic [7:0] ch);
      reply_t r;
      int     erased;
      r = '0;
      r.kind = EK_NONE;
      erased = 0;
      if (act == ACT_POP) begin
        if (closed && fill() > 0) begin
          r.read_valid = 1'b1;
          r.read_char  = line_buf[head];
          head = (head + 1) % DEPTH;
          if (fill() == 0) closed = 1'b0;
        end
      end else if (closed) begin
        r.refused = 1'b1;
      end else if (ch == CharCr) begin
        line_buf[tail] = CharNl;
        tail = (tail + 1) % DEPTH;
        closed = 1'b1;
        r.kind = EK_CRLF;
      end else if (ch == CharBs || ch == CharDel) begin
        if (fill() == 0) begin
          r.kind = EK_BELL;
        end else begin
          tail = (tail + DEPTH - 1) % DEPTH;
          r.kind = EK_ERASE;
          erased = 1;
        end
      end else if (ch == CharCtrlW) begin
        r.kind = EK_ERASE;
        while (fill() > 0 && !blank(line_buf[(tail + DEPTH - 1) % DEPTH])) begin
          tail = (tail + DEPTH - 1) % DEPTH;
          erased++;
        end
      end else if (ch == CharCtrlU) begin
        r.kind = EK_ERASE;
        erased = fill();
        tail = head;
      end else if (fill() >= DEPTH - 2) begin
        r.kind = EK_BELL;
      end else begin
        line_buf[tail] = ch;
        tail = (tail + 1) % DEPTH;
        r.kind = EK_ECHO;
        r.echo_char = ch;
      end
      r.erase_count = (erased > 255) ? 8'd255 : erased[7:0];
      return r;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void take_keystroke(act_e act, logic [7:0] ch);
      pending_replies.push_back(edit_line(act, ch));
    endfunction

    task match_reply(logic [23:0] data, logic [4:0] user);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected word tdata=%h tuser=%h", data, user));
      end else begin
        want = pending_replies.pop_front();
        if (user[2:0] !== want.kind)
          report($sformatf("echo_kind %0d, want %0d", user[2:0], want.kind));
        if (data[7:0] !== want.echo_char)
          report($sformatf("echo_char %h, want %h", data[7:0], want.echo_char));
        if (data[15:8] !== want.erase_count)
          report($sformatf("erase_count %0d, want %0d", data[15:8], want.erase_count));
        if (user[3] !== want.refused)
          report($sformatf("refused %b, want %b", user[3], want.refused));
        if (user[4] !== want.read_valid)
          report($sformatf("read_valid %b, want %b", user[4], want.read_valid));
        if (data[23:16] !== want.read_char)
          report($sformatf("read_char %h, want %h", data[23:16], want.read_char));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [4:0]  m_tuser;

  echo_tracker sb = new();
  int          words_sent = 0;
  bit          idle_on = 1'b1;
  longint      cycles = 0;
  int          stall_left = 0;

  console_line_editor_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL console_line_editor_unit");
      $finish;
    end
  end

  // Receiver: random stall bursts, none once the run calms down.
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.match_reply(m_tdata, m_tuser);
  end

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_word(act_e act, logic [7:0] ch);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = ch;
    do @(posedge clk_i); while (!s_tready);
    sb.take_keystroke(act, ch);
    words_sent++;
    if (words_sent >= CALM_AFTER) idle_on = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic key(logic [7:0] ch);
    send_word(ACT_RX, ch);
  endtask

  task automatic pop();
    send_word(ACT_POP, 8'($urandom));
  endtask

  // Type one line, with edits mixed in on short lines, usually close it, then drain it.
  task automatic type_line();
    int          target;
    int          pick;
    bit          long_line;
    logic [7:0]  ch;
    long_line = ($urandom_range(0, 14) == 0);
    target = long_line ? $urandom_range(118, 140) : $urandom_range(0, 20);
    for (int i = 0; i < target; i++) begin
      pick = $urandom_range(0, 99);
      if (long_line) begin
        ch = (pick < 10) ? CharSpace : 8'($urandom_range(8'h21, 8'h7E));
      end else if (pick < 6) begin
        ch = CharBs;
      end else if (pick < 10) begin
        ch = CharDel;
      end else if (pick < 15) begin
        ch = CharCtrlW;
      end else if (pick < 17) begin
        ch = CharCtrlU;
      end else if (pick < 27) begin
        ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(CharTab, CharCr)) : CharSpace;
      end else if (pick < 50) begin
        ch = 8'($urandom);
      end else begin
        ch = 8'($urandom_range(8'h21, 8'h7E));
      end
      key(ch);
    end
    if ($urandom_range(0, 9) != 0) key(CharCr);
    // Drain a closed line; receives in between must be refused.
    while (sb.closed) begin
      if ($urandom_range(0, 7) == 0) key(8'($urandom));
      else pop();
    end
    if ($urandom_range(0, 5) == 0) pop();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    pop();
    key(CharBs);
    key(CharDel);
    key(CharCtrlW);
    key(CharCtrlU);
    key(8'h61);
    key(8'h00);
    key(8'hFF);
    key(CharSpace);
    key(8'h62);
    key(CharCtrlW);
    key(CharCtrlW);
    key(CharBs);
    key(CharDel);
    key(CharCtrlU);
    key(8'h78);
    key(CharTab);
    key(8'h79);
    key(CharCr);
    key(8'h7A);
    pop();
    pop();
    pop();
    pop();
    pop();

    while (words_sent < WORD_COUNT) type_line();
    s_tvalid = 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 16) @(posedge clk_i);
    if (sb.pending_replies.size() != 0)
      sb.report($sformatf("%0d replies never came", sb.pending_replies.size()));
    if (sb.errors == 0) begin
      $display("PASS console_line_editor_unit");
    end else begin
      $display("FAIL console_line_editor_unit");
    end
    $finish;
  end

endmodule
